/* hdl/two_rotor_substitution_cipher_top_macros.svh */
// assertion macros used by the cipher core
`ifndef TWO_ROTOR_SUBSTITUTION_CIPHER_TOP_MACROS_SVH
`define TWO_ROTOR_SUBSTITUTION_CIPHER_TOP_MACROS_SVH

// same-cycle implication
`define TRSC_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trsc assertion failed");

// next-cycle implication
`define TRSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trsc assertion failed");

`endif

/* hdl/trsc_pkg.sv */
// types, constants and helper functions of the two-rotor cipher
package trsc_pkg;

  localparam int unsigned ROTOR_SIZE = 27;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned CMD_W      = 3;

  localparam logic [CMD_W-1:0] CMD_ENCODE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DECODE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_INNER  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WR_MIDDLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESTART   = 3'd4;

  localparam logic [SYM_W*ROTOR_SIZE-1:0] OUTER_WIRING  = "#BDFHJLNPRTVXZACEGIKMOQSUWY";
  localparam logic [SYM_W*ROTOR_SIZE-1:0] INNER_WIRING  = "#GNUAHOVBIPWCJQXDKRYELSZFMT";
  localparam logic [SYM_W*ROTOR_SIZE-1:0] MIDDLE_WIRING = "#EJOTYCHMRWAFKPUZDINSXBGLQV";

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [1:0] {
    TBL_INNER,
    TBL_MIDDLE,
    TBL_OUTER
  } tbl_e;

  typedef struct packed {
    tbl_e sel;
    pos_t addr;
  } rotor_rd_t;

  typedef struct packed {
    logic we;
    tbl_e sel;
    pos_t addr;
    sym_t data;
  } rotor_wr_t;

  typedef struct packed {
    pos_t inner_start;
    pos_t middle_start;
  } cfg_t;

  typedef struct packed {
    pos_t middle_offset_now;
    pos_t inner_offset_now;
    logic not_found;
    sym_t out_symbol;
  } result_t;

  // character at position i of a wiring string, first character in the top byte
  function automatic sym_t wiring_char(input logic [SYM_W*ROTOR_SIZE-1:0] w, input pos_t i);
    sym_t c;
    c = '0;
    if (i < POS_W'(ROTOR_SIZE)) begin
      c = w[SYM_W*(ROTOR_SIZE-1-int'(i)) +: SYM_W];
    end
    return c;
  endfunction

  // position plus or minus offset, modulo the rotor size
  function automatic pos_t mod_step(input pos_t p, input pos_t o, input logic sub);
    logic [POS_W:0] s;
    if (sub) begin
      s = {1'b0, p} - {1'b0, o};
      if (s[POS_W]) begin
        s = s + (POS_W+1)'(ROTOR_SIZE);
      end
    end else begin
      s = {1'b0, p} + {1'b0, o};
      if (s >= (POS_W+1)'(ROTOR_SIZE)) begin
        s = s - (POS_W+1)'(ROTOR_SIZE);
      end
    end
    return s[POS_W-1:0];
  endfunction

  function automatic pos_t reduce_pos(input pos_t v);
    return (v >= POS_W'(ROTOR_SIZE)) ? pos_t'(v - POS_W'(ROTOR_SIZE)) : v;
  endfunction

  function automatic pos_t step_down(input pos_t v);
    return (v == '0) ? pos_t'(ROTOR_SIZE - 1) : pos_t'(v - 1'b1);
  endfunction

endpackage

/* hdl/two_rotor_substitution_cipher_top.sv */
// top level of the two-rotor cipher: stream ports, register port, output register
//
// channel   direction  transfer when                 payload
// s_axis    in         tvalid & tready               command, symbol, table index
// m_axis    out        tvalid & tready               cipher symbol, miss flag, offsets
// apb       in         psel & penable & pwrite       inner_start, middle_start
//
// encode/decode takes the accept cycle, then two rounds of a table search over up to 27 entries
// (one entry compared per cycle) followed by a table read, then one offset step
// table writes, restart and unused commands finish in the accept cycle
// reset loads the default rotor wirings and zero offsets at once
// a finished result moves to the output register; the core waits only if it is still full
module two_rotor_substitution_cipher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // symbol[7:0], entry_index[12:8], zeros
  input  logic [2:0]  s_axis_tuser_i,  // cmd[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // out_symbol[7:0], not_found[8],
                                       // inner_offset_now[13:9], middle_offset_now[18:14], zeros
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import trsc_pkg::*;

  cfg_t      cfg_q;
  logic      m_valid_q;
  result_t   m_data_q;

  rotor_rd_t rd;
  rotor_wr_t wr;
  sym_t      rd_data;
  logic      res_valid;
  logic      res_ready;
  result_t   res;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {27'b0, cfg_q.middle_start} : {27'b0, cfg_q.inner_start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        cfg_q.middle_start <= reduce_pos(pwdata[POS_W-1:0]);
      end else begin
        cfg_q.inner_start <= reduce_pos(pwdata[POS_W-1:0]);
      end
    end
  end

  trsc_rotor u_rotor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  trsc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_symbol_i (s_axis_tdata_i[7:0]),
    .in_index_i  (s_axis_tdata_i[12:8]),
    .cfg_i       (cfg_q),
    .rd_o        (rd),
    .rd_data_i   (rd_data),
    .wr_o        (wr),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
      if (res_valid) begin
        m_data_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b0, m_data_q};

endmodule

/* hdl/trsc_rotor.sv */
// writable inner and middle rotor tables with one read port
module trsc_rotor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trsc_pkg::rotor_wr_t wr_i,
  input  trsc_pkg::rotor_rd_t rd_i,
  output trsc_pkg::sym_t      rd_data_o
);
  import trsc_pkg::*;

  sym_t inner_q  [ROTOR_SIZE];
  sym_t middle_q [ROTOR_SIZE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROTOR_SIZE; i++) begin
        inner_q[i]  <= wiring_char(INNER_WIRING, POS_W'(i));
        middle_q[i] <= wiring_char(MIDDLE_WIRING, POS_W'(i));
      end
    end else if (wr_i.we && (wr_i.addr < POS_W'(ROTOR_SIZE))) begin
      if (wr_i.sel == TBL_MIDDLE) begin
        middle_q[wr_i.addr] <= wr_i.data;
      end else begin
        inner_q[wr_i.addr] <= wr_i.data;
      end
    end
  end

  always_comb begin
    if (rd_i.sel == TBL_MIDDLE) begin
      rd_data_o = middle_q[rd_i.addr];
    end else begin
      rd_data_o = inner_q[rd_i.addr];
    end
  end

endmodule

/* hdl/trsc_core.sv */
// sequencer with a shared table compare and modular offset unit
`include "two_rotor_substitution_cipher_top_macros.svh"

module trsc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          in_cmd_i,
  input  trsc_pkg::sym_t      in_symbol_i,
  input  trsc_pkg::pos_t      in_index_i,
  input  trsc_pkg::cfg_t      cfg_i,
  output trsc_pkg::rotor_rd_t rd_o,
  input  trsc_pkg::sym_t      rd_data_i,
  output trsc_pkg::rotor_wr_t wr_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output trsc_pkg::result_t   res_o
);
  import trsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_STEP,
    S_DONE
  } state_e;

  state_e state_q;
  logic   dec_q;
  logic   stage_q;
  logic   miss_q;
  pos_t   cnt_q;
  pos_t   pos_q;
  sym_t   key_q;
  pos_t   inner_off_q;
  pos_t   middle_off_q;

  logic   accept;
  tbl_e   search_tbl;
  tbl_e   read_tbl;
  pos_t   read_off;
  pos_t   read_addr;
  sym_t   entry;
  logic   hit;
  pos_t   inner_next;

  logic   cipher_cmd;
  logic   off_ok;
  logic   done_wait;
  logic   search_start;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (dec_q) begin
      search_tbl = TBL_OUTER;
      read_tbl   = stage_q ? TBL_INNER : TBL_MIDDLE;
    end else begin
      search_tbl = stage_q ? TBL_MIDDLE : TBL_INNER;
      read_tbl   = TBL_OUTER;
    end
    read_off  = (stage_q == dec_q) ? inner_off_q : middle_off_q;
    read_addr = mod_step(pos_q, read_off, !dec_q);

    if (state_q == S_READ) begin
      rd_o.sel  = read_tbl;
      rd_o.addr = read_addr;
    end else begin
      rd_o.sel  = search_tbl;
      rd_o.addr = cnt_q;
    end
    entry = (rd_o.sel == TBL_OUTER) ? wiring_char(OUTER_WIRING, rd_o.addr) : rd_data_i;
    hit   = (entry == key_q);

    inner_next = step_down(inner_off_q);
  end

  always_comb begin
    wr_o.we   = accept && ((in_cmd_i == CMD_WR_INNER) || (in_cmd_i == CMD_WR_MIDDLE));
    wr_o.sel  = (in_cmd_i == CMD_WR_MIDDLE) ? TBL_MIDDLE : TBL_INNER;
    wr_o.addr = in_index_i;
    wr_o.data = in_symbol_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dec_q        <= 1'b0;
      stage_q      <= 1'b0;
      miss_q       <= 1'b0;
      cnt_q        <= '0;
      pos_q        <= '0;
      key_q        <= '0;
      inner_off_q  <= '0;
      middle_off_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (in_cmd_i)
              CMD_ENCODE, CMD_DECODE: begin
                dec_q   <= (in_cmd_i == CMD_DECODE);
                stage_q <= 1'b0;
                miss_q  <= 1'b0;
                cnt_q   <= '0;
                key_q   <= in_symbol_i;
                state_q <= S_SEARCH;
              end
              CMD_RESTART: begin
                inner_off_q  <= cfg_i.inner_start;
                middle_off_q <= cfg_i.middle_start;
              end
              default: ;
            endcase
          end
        end
        S_SEARCH: begin
          if (hit) begin
            pos_q   <= cnt_q;
            state_q <= S_READ;
          end else if (cnt_q == pos_t'(ROTOR_SIZE - 1)) begin
            pos_q   <= '0;
            miss_q  <= 1'b1;
            state_q <= S_READ;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_READ: begin
          key_q <= entry;
          if (stage_q) begin
            state_q <= S_STEP;
          end else begin
            stage_q <= 1'b1;
            cnt_q   <= '0;
            state_q <= S_SEARCH;
          end
        end
        S_STEP: begin
          inner_off_q <= inner_next;
          if (inner_next == cfg_i.inner_start) begin
            middle_off_q <= step_down(middle_off_q);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o             = (state_q == S_DONE);
  assign res_o.out_symbol        = key_q;
  assign res_o.not_found         = miss_q;
  assign res_o.inner_offset_now  = inner_off_q;
  assign res_o.middle_offset_now = middle_off_q;

  assign cipher_cmd   = (in_cmd_i == CMD_ENCODE) || (in_cmd_i == CMD_DECODE);
  assign off_ok       = (inner_off_q < POS_W'(ROTOR_SIZE)) && (middle_off_q < POS_W'(ROTOR_SIZE));
  assign done_wait    = res_valid_o && !res_ready_i;
  assign search_start = (state_q == S_SEARCH) && (cnt_q == '0) && !miss_q && !stage_q;

  `TRSC_ASSERT(a_cnt_range, clk_i, rst_ni, state_q == S_SEARCH, cnt_q < POS_W'(ROTOR_SIZE))
  `TRSC_ASSERT(a_off_range, clk_i, rst_ni, state_q != S_IDLE, off_ok)
  `TRSC_ASSERT_NEXT(a_done_hold, clk_i, rst_ni, done_wait, res_valid_o && $stable(res_o))
  `TRSC_ASSERT_NEXT(a_cipher_start, clk_i, rst_ni, accept && cipher_cmd, search_start)

endmodule
